// File: hw/rtl/sffr_pkg.sv
// shared types and constants of the slip float frame receiver
package sffr_pkg;

	localparam int RAW_BUFFER_BYTES_DEF = 256;
	localparam int MAX_VALUES_DEF       = 16;

	localparam int BYTE_W = 8;
	localparam int VC_W   = 5;
	localparam int IDX_W  = 4;
	localparam int WORD_W = 32;
	localparam int LEN_W  = 7;
	localparam int KIND_W = 2;

	localparam logic [BYTE_W-1:0] SLIP_END     = 8'hC0;
	localparam logic [BYTE_W-1:0] SLIP_ESC     = 8'hDB;
	localparam logic [BYTE_W-1:0] SLIP_ESC_END = 8'hDC;
	localparam logic [BYTE_W-1:0] SLIP_ESC_ESC = 8'hDD;

	localparam logic [VC_W-1:0] VALUE_COUNT_RST = 5'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_VALUE   = 2'd0,
		KIND_BAD_LEN = 2'd1,
		KIND_OVERRUN = 2'd2
	} kind_t;

	// one frame-end job handed from front to back
	typedef struct packed {
		kind_t             kind;
		logic [LEN_W-1:0]  len;
		logic [VC_W-1:0]   nwords;
	} cmd_t;

endpackage

// File: hw/rtl/sffr_ram.sv
// generic simple dual-port ram with registered read
module sffr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hw/rtl/sffr_front.sv
// front: slip deframing, payload store writes and frame-end job issue
module sffr_front #(
	parameter int RAW_BUFFER_BYTES = sffr_pkg::RAW_BUFFER_BYTES_DEF,
	parameter int MAX_VALUES       = sffr_pkg::MAX_VALUES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [sffr_pkg::BYTE_W-1:0]           rx_byte,
	input  logic                                  cfg_valid,
	input  logic [sffr_pkg::VC_W-1:0]             cfg_data,
	input  logic                                  q_full,
	input  logic                                  back_busy,
	output logic                                  push,
	output sffr_pkg::cmd_t                        push_cmd,
	output logic                                  wr_en,
	output logic [$clog2(4*MAX_VALUES)-1:0]       wr_addr,
	output logic [sffr_pkg::BYTE_W-1:0]           wr_data
);

	import sffr_pkg::*;

	localparam int STORE  = 4 * MAX_VALUES;
	localparam int ADDR_W = $clog2(STORE);
	localparam int PAY_W  = $clog2(STORE + 2);
	localparam int RAW_W  = $clog2(RAW_BUFFER_BYTES + 1);

	logic              in_frame_q;
	logic              esc_q;
	logic [RAW_W-1:0]  raw_cnt_q;
	logic [PAY_W-1:0]  pay_cnt_q;
	logic [VC_W-1:0]   value_count_q;

	logic              accept;
	logic              take;
	logic [BYTE_W-1:0] take_byte;
	logic              len_ok;
	logic              vc_ok;

	assign in_stall = q_full || (in_frame_q && back_busy);
	assign accept   = in_valid && !in_stall;

	assign vc_ok  = 32'(value_count_q) <= 32'(MAX_VALUES);
	assign len_ok = 32'(pay_cnt_q) == 32'({value_count_q, 2'b00});

	always_comb begin
		push      = 1'b0;
		push_cmd  = '{kind: KIND_BAD_LEN, len: LEN_W'(pay_cnt_q), nwords: value_count_q};
		take      = 1'b0;
		take_byte = rx_byte;
		if (accept && in_frame_q) begin
			if (raw_cnt_q == RAW_W'(RAW_BUFFER_BYTES)) begin
				push          = 1'b1;
				push_cmd.kind = KIND_OVERRUN;
			end else if (rx_byte == SLIP_END) begin
				if (vc_ok && len_ok) begin
					push_cmd.kind = KIND_VALUE;
					push          = value_count_q != '0;
				end else begin
					push = 1'b1;
				end
			end else if (esc_q) begin
				take = 1'b1;
				if (rx_byte == SLIP_ESC_END) begin
					take_byte = SLIP_END;
				end else if (rx_byte == SLIP_ESC_ESC) begin
					take_byte = SLIP_ESC;
				end
			end else if (rx_byte != SLIP_ESC) begin
				take = 1'b1;
			end
		end
	end

	assign wr_en   = take && (32'(pay_cnt_q) < 32'(STORE));
	assign wr_addr = pay_cnt_q[ADDR_W-1:0];
	assign wr_data = take_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_count_q <= VALUE_COUNT_RST;
		end else if (cfg_valid) begin
			value_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			raw_cnt_q  <= '0;
			pay_cnt_q  <= '0;
		end else if (accept) begin
			if (!in_frame_q) begin
				if (rx_byte == SLIP_END) begin
					in_frame_q <= 1'b1;
					esc_q      <= 1'b0;
					raw_cnt_q  <= '0;
					pay_cnt_q  <= '0;
				end
			end else if (raw_cnt_q == RAW_W'(RAW_BUFFER_BYTES) || rx_byte == SLIP_END) begin
				in_frame_q <= 1'b0;
				esc_q      <= 1'b0;
				raw_cnt_q  <= '0;
			end else begin
				raw_cnt_q <= raw_cnt_q + RAW_W'(1);
				esc_q     <= !esc_q && rx_byte == SLIP_ESC;
				if (take && 32'(pay_cnt_q) < 32'(STORE + 1)) begin
					pay_cnt_q <= pay_cnt_q + PAY_W'(1);
				end
			end
		end
	end

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into full queue");

	a_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> in_frame_q && !back_busy)
		else $error("payload store written while back part reads it");

endmodule

// File: hw/rtl/sffr_cmd_fifo.sv
// two-entry job queue between front and back
module sffr_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sffr_pkg::cmd_t push_cmd,
	input  logic           pop,
	output sffr_pkg::cmd_t pop_cmd,
	output logic           full,
	output logic           empty
);

	import sffr_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign pop_cmd = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: hw/rtl/sffr_back.sv
// back: runs frame-end jobs, reads words from the store, drives the result register
module sffr_back #(
	parameter int MAX_VALUES = sffr_pkg::MAX_VALUES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  sffr_pkg::cmd_t                    q_cmd,
	output logic                              pop,
	output logic                              busy,
	output logic                              rd_en,
	output logic [$clog2(4*MAX_VALUES)-1:0]   rd_addr,
	input  logic [sffr_pkg::BYTE_W-1:0]       rd_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sffr_pkg::KIND_W-1:0]       kind,
	output logic [sffr_pkg::IDX_W-1:0]        value_index,
	output logic [sffr_pkg::WORD_W-1:0]       value_bits,
	output logic [sffr_pkg::LEN_W-1:0]        decoded_length,
	output logic                              last
);

	import sffr_pkg::*;

	localparam int ADDR_W = $clog2(4 * MAX_VALUES);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_PUSH  = 4'b1000
	} state_t;

	state_t            st_q;
	cmd_t              cmd_q;
	logic [VC_W-1:0]   word_q;
	logic [1:0]        byte_q;
	logic [WORD_W-1:0] asm_q;
	logic              rd_vld_s1;
	logic [1:0]        rd_lane_s1;
	logic              out_free;
	logic              word_last;

	assign busy      = st_q != ST_IDLE;
	assign pop       = st_q == ST_IDLE && !q_empty;
	assign rd_en     = st_q == ST_FETCH;
	assign rd_addr   = ADDR_W'({word_q, byte_q});
	assign out_free  = !out_valid || !out_stall;
	assign word_last = cmd_q.kind != KIND_VALUE || word_q + VC_W'(1) == cmd_q.nwords;

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
		rd_lane_s1 <= byte_q;
		if (rd_vld_s1) begin
			asm_q[rd_lane_s1*BYTE_W +: BYTE_W] <= rd_data;
		end
		if (st_q == ST_PUSH && out_free) begin
			kind           <= cmd_q.kind;
			decoded_length <= cmd_q.len;
			last           <= word_last;
			value_index    <= cmd_q.kind == KIND_VALUE ? word_q[IDX_W-1:0] : '0;
			value_bits     <= cmd_q.kind == KIND_VALUE ? asm_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			word_q    <= '0;
			byte_q    <= '0;
			rd_vld_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (st_q == ST_PUSH && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					word_q <= '0;
					byte_q <= '0;
					if (!q_empty) begin
						st_q <= q_cmd.kind == KIND_VALUE ? ST_FETCH : ST_PUSH;
					end
				end
				ST_FETCH: begin
					byte_q <= byte_q + 2'd1;
					if (byte_q == 2'd3) begin
						st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					st_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (out_free) begin
						if (word_last) begin
							st_q <= ST_IDLE;
						end else begin
							word_q <= word_q + VC_W'(1);
							byte_q <= '0;
							st_q   <= ST_FETCH;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_report_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_VALUE |-> last && value_bits == '0 && value_index == '0)
		else $error("status result with nonzero word fields");

	a_read_from_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(st_q == ST_FETCH))
		else $error("store read outside fetch");

	a_word_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_PUSH && cmd_q.kind == KIND_VALUE |-> word_q < cmd_q.nwords)
		else $error("word index past job length");

endmodule

// File: hw/rtl/slip_float_frame_receiver_core.sv
// top level of the slip float frame receiver
//
// Input channel: one raw serial byte per transfer on rx_byte, taken when in_valid is
// high and in_stall is low. Output channel: result items held in a register, taken
// when out_valid is high and out_stall is low. Configuration: value_count is written
// through cfg_valid/cfg_data; cfg_ready is always high.
// A closing END queues one job, none for a well-formed frame while value_count is 0.
// The back part pops the job; a status result goes straight to PUSH, which loads the
// result register. For each value word FETCH makes four store reads at one per cycle,
// DRAIN lets the last read land and PUSH loads the result register.
// While a job is queued or running, further in-frame bytes are stalled; bytes outside
// a frame, the opening END included, pass at one per cycle. A stalled output register
// holds the back part and with it the in-frame bytes; the two-entry job queue never
// fills, as the front issues a job only while the back part is idle.
// Reset clears frame state and the job queue and sets value_count to 1; the payload
// store needs no clearing, as only bytes written in the current frame are read.
module slip_float_frame_receiver_core #(
	parameter int RAW_BUFFER_BYTES = sffr_pkg::RAW_BUFFER_BYTES_DEF,
	parameter int MAX_VALUES       = sffr_pkg::MAX_VALUES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sffr_pkg::BYTE_W-1:0] rx_byte,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sffr_pkg::VC_W-1:0]   cfg_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sffr_pkg::KIND_W-1:0] kind,
	output logic [sffr_pkg::IDX_W-1:0]  value_index,
	output logic [sffr_pkg::WORD_W-1:0] value_bits,
	output logic [sffr_pkg::LEN_W-1:0]  decoded_length,
	output logic                        last
);

	import sffr_pkg::*;

	localparam int STORE  = 4 * MAX_VALUES;
	localparam int ADDR_W = $clog2(STORE);

	logic              q_full;
	logic              q_empty;
	logic              push;
	logic              pop;
	cmd_t              push_cmd;
	cmd_t              pop_cmd;
	logic              back_busy;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [BYTE_W-1:0] rd_data;

	assign cfg_ready = 1'b1;

	sffr_front #(
		.RAW_BUFFER_BYTES(RAW_BUFFER_BYTES),
		.MAX_VALUES(MAX_VALUES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.q_full(q_full),
		.back_busy(back_busy || !q_empty),
		.push(push),
		.push_cmd(push_cmd),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	sffr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	sffr_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.pop_cmd(pop_cmd),
		.full(q_full),
		.empty(q_empty)
	);

	sffr_back #(
		.MAX_VALUES(MAX_VALUES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_cmd(pop_cmd),
		.pop(pop),
		.busy(back_busy),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.value_index(value_index),
		.value_bits(value_bits),
		.decoded_length(decoded_length),
		.last(last)
	);

endmodule
